// ----- rtl/core/lcapw_pkg.sv -----
package lcapw_pkg;

    localparam int NODE_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_EDGE  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // operations handed from the front end to the walk engine
    typedef enum logic [1:0] {
        OP_EDGE   = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_ANSWER = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic                found;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- rtl/core/lcapw_front.sv -----
module lcapw_front
    import lcapw_pkg::*;
#(
    parameter int NODES = 256
) (
    input  logic [1:0]        cmd,
    input  logic [NODE_W-1:0] first_node,
    input  logic [NODE_W-1:0] second_node,
    output logic              push,
    output op_t               op
);

    localparam int SLOTS = (NODES < 256) ? NODES : 256;

    logic a_ok;
    logic b_ok;

    assign a_ok = ({1'b0, first_node} < 9'(SLOTS));
    assign b_ok = ({1'b0, second_node} < 9'(SLOTS));

    always_comb begin
        push        = 1'b0;
        op.kind     = OP_EDGE;
        op.found    = 1'b0;
        op.node_a   = first_node;
        op.node_b   = second_node;
        case (cmd_t'(cmd))
            CMD_EDGE: begin
                push    = a_ok && b_ok;
                op.kind = OP_EDGE;
            end
            CMD_QUERY: begin
                push = 1'b1;
                if (!a_ok || !b_ok) begin
                    op.kind   = OP_ANSWER;
                    op.node_a = '0;
                end else if (first_node == second_node) begin
                    // a node is its own common ancestor
                    op.kind  = OP_ANSWER;
                    op.found = 1'b1;
                end else begin
                    op.kind = OP_QUERY;
                end
            end
            CMD_CLEAR: begin
                push    = 1'b1;
                op.kind = OP_CLEAR;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/lcapw_queue.sv -----
module lcapw_queue
    import lcapw_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  op_t           push_op,
    input  logic          pop,
    output op_t           head_op,
    output queue_status_t status
);

    op_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_op      = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- rtl/core/lcapw_back.sv -----
module lcapw_back
    import lcapw_pkg::*;
#(
    parameter int NODES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  op_t               op,
    input  logic              op_valid,
    output logic              op_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tuser
);

    localparam int SLOTS  = (NODES < 256) ? NODES : 256;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int STEP_W = $clog2(NODES);
    localparam int TAG_W  = 8;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NODES - 1);
    localparam logic [TAG_W-1:0]  TAG_MAX   = '1;
    localparam logic [ADDR_W-1:0] WIPE_LAST = ADDR_W'(SLOTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WALK_U = 5'b00010,
        ST_WALK_V = 5'b00100,
        ST_DONE   = 5'b01000,
        ST_WIPE   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [NODE_W-1:0]   v_reg, v_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic                res_found_reg, res_found_next;
    logic [NODE_W-1:0]   res_anc_reg, res_anc_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg, m_found_next;
    logic [NODE_W-1:0]   m_anc_reg, m_anc_next;
    logic [TAG_W-1:0]    epoch_reg, epoch_next;
    logic [ADDR_W-1:0]   wipe_reg, wipe_next;
    logic                mark_fwd_reg, mark_fwd_next;

    logic [NODE_W-1:0]   parent_mem [SLOTS];
    logic [NODE_W-1:0]   rdata_reg;
    logic [NODE_W-1:0]   rd_addr;
    logic                mem_we;
    logic [SLOTS-1:0]    has_parent_reg;
    logic                clear_all;
    // path marks: a node is on the path when its tag equals the current epoch
    logic [TAG_W-1:0]    mark_mem [SLOTS];
    logic [TAG_W-1:0]    mark_rdata_reg;
    logic                mark_we;
    logic [ADDR_W-1:0]   mark_waddr;
    logic [TAG_W-1:0]    mark_wdata;
    logic                out_free;
    logic                cur_has_parent;
    logic                cur_on_path;

    assign out_free       = !m_valid_reg || m_axis_tready;
    assign cur_has_parent = has_parent_reg[cur_reg[ADDR_W-1:0]];
    assign cur_on_path    = mark_fwd_reg || (mark_rdata_reg == epoch_reg);

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        v_next         = v_reg;
        steps_next     = steps_reg;
        res_found_next = res_found_reg;
        res_anc_next   = res_anc_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_found_next   = m_found_reg;
        m_anc_next     = m_anc_reg;
        epoch_next     = epoch_reg;
        wipe_next      = wipe_reg;
        mark_fwd_next  = 1'b0;
        rd_addr        = cur_reg;
        mem_we         = 1'b0;
        clear_all      = 1'b0;
        mark_we        = 1'b0;
        mark_waddr     = cur_reg[ADDR_W-1:0];
        mark_wdata     = epoch_reg;
        op_pop         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (op_valid) begin
                    case (op.kind)
                        OP_EDGE: begin
                            op_pop = 1'b1;
                            mem_we = 1'b1;
                        end
                        OP_CLEAR: begin
                            op_pop    = 1'b1;
                            clear_all = 1'b1;
                        end
                        OP_ANSWER: begin
                            if (out_free) begin
                                op_pop       = 1'b1;
                                m_valid_next = 1'b1;
                                m_found_next = op.found;
                                m_anc_next   = op.node_a;
                            end
                        end
                        OP_QUERY: begin
                            if (epoch_reg == TAG_MAX) begin
                                // tags used up: wipe the marks before this query
                                wipe_next  = '0;
                                state_next = ST_WIPE;
                            end else begin
                                op_pop     = 1'b1;
                                epoch_next = epoch_reg + 1'b1;
                                cur_next   = op.node_a;
                                v_next     = op.node_b;
                                steps_next = '0;
                                rd_addr    = op.node_a;
                                state_next = ST_WALK_U;
                            end
                        end
                        default: begin
                            op_pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK_U: begin
                // mark the node, then climb toward the root
                mark_we = 1'b1;
                if (!cur_has_parent) begin
                    // the root mark lands in the same cycle as the read of v
                    mark_fwd_next = (v_reg == cur_reg);
                    cur_next      = v_reg;
                    rd_addr       = v_reg;
                    steps_next    = '0;
                    state_next    = ST_WALK_V;
                end else if (steps_reg == STEP_LAST) begin
                    res_found_next = 1'b0;
                    res_anc_next   = '0;
                    state_next     = ST_DONE;
                end else begin
                    cur_next   = rdata_reg;
                    rd_addr    = rdata_reg;
                    steps_next = steps_reg + 1'b1;
                end
            end
            ST_WALK_V: begin
                if (cur_on_path) begin
                    res_found_next = 1'b1;
                    res_anc_next   = cur_reg;
                    state_next     = ST_DONE;
                end else if (!cur_has_parent || steps_reg == STEP_LAST) begin
                    res_found_next = 1'b0;
                    res_anc_next   = '0;
                    state_next     = ST_DONE;
                end else begin
                    cur_next   = rdata_reg;
                    rd_addr    = rdata_reg;
                    steps_next = steps_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_anc_next   = res_anc_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_WIPE: begin
                // one tag entry per cycle back to zero
                mark_we    = 1'b1;
                mark_waddr = wipe_reg;
                mark_wdata = '0;
                if (wipe_reg == WIPE_LAST) begin
                    epoch_next = '0;
                    state_next = ST_IDLE;
                end else begin
                    wipe_next = wipe_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_WIPE;
            m_valid_reg    <= 1'b0;
            has_parent_reg <= '0;
            epoch_reg      <= '0;
            wipe_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            epoch_reg   <= epoch_next;
            wipe_reg    <= wipe_next;
            if (clear_all) begin
                has_parent_reg <= '0;
            end else if (mem_we) begin
                has_parent_reg[op.node_b[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        v_reg         <= v_next;
        steps_reg     <= steps_next;
        res_found_reg <= res_found_next;
        res_anc_reg   <= res_anc_next;
        m_found_reg   <= m_found_next;
        m_anc_reg     <= m_anc_next;
        mark_fwd_reg  <= mark_fwd_next;
    end

    // parent table, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            parent_mem[op.node_b[ADDR_W-1:0]] <= op.node_a;
        end
        rdata_reg <= parent_mem[rd_addr[ADDR_W-1:0]];
    end

    // path tags, read at the same address as the parent table
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rdata_reg <= mark_mem[rd_addr[ADDR_W-1:0]];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_anc_reg;
    assign m_axis_tuser  = m_found_reg;

endmodule

// ----- rtl/core/lowest_common_ancestor_parent_walk_unit.sv -----
// lowest common ancestor by parent walk. the unit keeps a parent table for a
// rooted tree of up to min(NODES, 256) nodes, all entries "no parent" after
// reset. s_axis_tuser picks the command: 0 records first_node as the parent of
// second_node (edges naming a node out of range are dropped), 1 asks for the
// lowest common ancestor of first_node and second_node and returns exactly one
// word, 2 clears the whole table, 3 is ignored. a query walks from first_node
// to the root marking the path, then climbs from second_node until it meets a
// marked node; no meeting point, a node out of range, or a walk of NODES or
// more steps (a cycle) gives found = 0 with ancestor 0, and equal nodes answer
// themselves at once. commands land in a four-word queue, so the input keeps
// flowing while a walk runs. edge, clear and trivial queries are handled
// straight from idle; a real query visits the path of first_node, then the
// nodes from second_node, as the engine reads one parent table entry per cycle
// through a single registered read port. path marks are per-node query tags
// in a second memory; after reset and after every 255 walks the engine wipes
// the tags of all min(NODES, 256) slots before it takes the next command,
// while words keep landing in the queue until it is full. the result word sits
// in an output register and waits for m_axis_tready; edges, clears and walks go
// on meanwhile, but the next answer waits until the register is free.
module lowest_common_ancestor_parent_walk_unit
    import lcapw_pkg::*;
#(
    parameter int NODES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // first_node [7:0], second_node [15:8]
    input  logic [1:0]  s_axis_tuser,    // cmd [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // ancestor [7:0]
    output logic        m_axis_tuser     // found [0]
);

    logic          front_push;
    op_t           front_op;
    op_t           head_op;
    queue_status_t q_status;
    logic          q_pop;
    logic          s_accept;

    // input word accepted whenever the queue has room
    assign s_axis_tready = !q_status.full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // front end: sort commands, answer trivial queries early
    lcapw_front #(
        .NODES (NODES)
    ) u_front (
        .cmd         (s_axis_tuser),
        .first_node  (s_axis_tdata[7:0]),
        .second_node (s_axis_tdata[15:8]),
        .push        (front_push),
        .op          (front_op)
    );

    // decoupling queue between front end and walk engine
    lcapw_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_accept && front_push),
        .push_op (front_op),
        .pop     (q_pop),
        .head_op (head_op),
        .status  (q_status)
    );

    // walk engine with the parent table and the path tags
    lcapw_back #(
        .NODES (NODES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (head_op),
        .op_valid      (!q_status.empty),
        .op_pop        (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // a missing ancestor always reads as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'd0))
        else $error("result without ancestor carries a nonzero node");

    // the engine never pops an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("pop from empty command queue");

    // queue status flags never contradict each other
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("command queue both full and empty");

    // no result word right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

// ----- tb/sv/lca_answer_checker.sv -----
`timescale 1ns / 100ps

// watches both channels, keeps its own parent table and predicts one answer
// word per accepted query word
module lca_answer_checker
    import lcapw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // first_node [7:0], second_node [15:8]
    input  logic [1:0]  s_axis_tuser,    // cmd [1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,    // ancestor [7:0]
    input  logic        m_axis_tuser,    // found [0]
    output int          mismatch_count,
    output int          answers_pending
);

    localparam logic [8:0] NO_PARENT = 9'h100;

    typedef struct packed {
        logic [7:0] ancestor;
        logic       found;
    } lca_answer_t;

    logic [8:0]  parent_tbl [256];    // bit 8 set: no parent
    lca_answer_t answer_q [$];
    int          errs = 0;

    function automatic lca_answer_t predict_ancestor(input logic [7:0] u, input logic [7:0] v);
        bit          marked [256];
        logic [7:0]  cur;
        bit          at_root;
        lca_answer_t ans;
        foreach (marked[i]) marked[i] = 1'b0;
        ans     = '0;
        at_root = 1'b0;
        if (u == v) begin
            ans.ancestor = u;
            ans.found    = 1'b1;
            return ans;
        end
        // mark the path of u, give up on a cycle
        cur = u;
        for (int step = 0; step < 256; step++) begin
            marked[cur] = 1'b1;
            if (parent_tbl[cur][8]) begin
                at_root = 1'b1;
                break;
            end
            cur = parent_tbl[cur][7:0];
        end
        if (!at_root) return ans;
        // climb from v to the first marked node
        cur = v;
        for (int step = 0; step < 256; step++) begin
            if (marked[cur]) begin
                ans.ancestor = cur;
                ans.found    = 1'b1;
                return ans;
            end
            if (parent_tbl[cur][8]) return ans;
            cur = parent_tbl[cur][7:0];
        end
        return ans;
    endfunction

    always @(posedge aclk) begin : watch_words
        lca_answer_t want;
        cmd_t        cmd;
        logic [7:0]  node_a;
        logic [7:0]  node_b;
        if (!aresetn) begin
            foreach (parent_tbl[i]) parent_tbl[i] = NO_PARENT;
            answer_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                cmd    = cmd_t'(s_axis_tuser);
                node_a = s_axis_tdata[7:0];
                node_b = s_axis_tdata[15:8];
                case (cmd)
                    CMD_EDGE:  parent_tbl[node_b] = {1'b0, node_a};
                    CMD_QUERY: answer_q.insert(answer_q.size(),
                                               predict_ancestor(node_a, node_b));
                    CMD_CLEAR: foreach (parent_tbl[i]) parent_tbl[i] = NO_PARENT;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: answer word with none expected, expected nothing,%s",
                             $time, " actual:");
                    $display("%0t: actual ancestor %0d found %0b",
                             $time, m_axis_tdata, m_axis_tuser);
                    errs++;
                end else begin
                    want = answer_q.pop_front();
                    if (m_axis_tdata !== want.ancestor) begin
                        $display("%0t: ancestor mismatch, expected %0d, actual %0d",
                                 $time, want.ancestor, m_axis_tdata);
                        errs++;
                    end
                    if (m_axis_tuser !== want.found) begin
                        $display("%0t: found mismatch, expected %0b, actual %0b",
                                 $time, want.found, m_axis_tuser);
                        errs++;
                    end
                end
            end
        end
        mismatch_count  <= errs;
        answers_pending <= answer_q.size();
    end

endmodule

// ----- tb/sv/lowest_common_ancestor_parent_walk_unit_tb.sv -----
`timescale 1ns / 100ps

// stimulus and verdict for the parent walk unit; the checker beside the dut
// does all prediction and comparison
module lowest_common_ancestor_parent_walk_unit_tb;
    import lcapw_pkg::*;

    localparam int NODES          = 256;
    localparam int RANDOM_WORDS   = 1120;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2 * NODES + 16;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;

    int          mismatch_count;
    int          answers_pending;
    int          burst_left  = 0;
    int          words_sent  = 0;
    int          idle_cycles = 0;
    int          stall_mode  = 0;
    int          stall_left  = 0;
    int unsigned cycle_no    = 0;

    always #5 aclk = ~aclk;

    lowest_common_ancestor_parent_walk_unit #(
        .NODES(NODES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lca_answer_checker answer_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .answers_pending (answers_pending)
    );

    // receiver: switches between always ready, coin flip, periodic and long stalls
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(150, 400);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (cycle_no[2:0] != 3'd0);
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // watchdog: too long without any word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // one input word; bursts of random length with random gaps between them
    task automatic send_word(input cmd_t cmd, input logic [7:0] first_node,
                             input logic [7:0] second_node);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {second_node, first_node};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        burst_left--;
        words_sent++;
    endtask

    // hold the input until every query has been answered
    task automatic drain_answers();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (answers_pending != 0) @(posedge aclk);
    endtask

    // node label with the extremes favored
    function automatic logic [7:0] any_node();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // random tree over a few labels, then queries and re-parenting
    task automatic tree_sequence();
        logic [7:0] label [24];
        int         k;
        int         pick_a;
        int         pick_b;
        if ($urandom_range(0, 3) != 0) send_word(CMD_CLEAR, any_node(), any_node());
        k = $urandom_range(2, 24);
        for (int i = 0; i < k; i++) label[i] = any_node();
        for (int i = 1; i < k; i++) send_word(CMD_EDGE, label[$urandom_range(0, i - 1)], label[i]);
        // close a loop back to the root now and then
        if ($urandom_range(0, 7) == 0) send_word(CMD_EDGE, label[k - 1], label[0]);
        repeat ($urandom_range(2, 10)) begin
            pick_a = $urandom_range(0, k - 1);
            pick_b = $urandom_range(0, k - 1);
            case ($urandom_range(0, 7))
                0: send_word(CMD_QUERY, label[pick_a], any_node());
                1: send_word(CMD_EDGE, label[pick_a], label[pick_b]);
                2: send_word(CMD_QUERY, label[pick_a], label[pick_a]);
                default: send_word(CMD_QUERY, label[pick_a], label[pick_b]);
            endcase
        end
    endtask

    // any command, any nodes, including the unused code
    task automatic noise_words();
        repeat ($urandom_range(1, 6))
            send_word(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
    endtask

    // a path through all nodes, then the same path closed into a full ring
    task automatic chain_sequence();
        send_word(CMD_CLEAR, 8'd0, 8'd0);
        for (int i = 0; i < 255; i++) send_word(CMD_EDGE, 8'(i), 8'(i + 1));
        send_word(CMD_QUERY, 8'd255, 8'd254);
        send_word(CMD_QUERY, 8'd255, 8'd128);
        send_word(CMD_QUERY, 8'd200, 8'd255);
        send_word(CMD_QUERY, 8'd1, 8'd255);
        send_word(CMD_EDGE, 8'd255, 8'd0);
        send_word(CMD_QUERY, 8'd255, 8'd100);
        send_word(CMD_QUERY, 8'd3, 8'd9);
        send_word(CMD_CLEAR, 8'd0, 8'd0);
    endtask

    initial begin : stimulus
        int  random_start;
        bit  chain_done;
        chain_done = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extremes, re-parenting, self edge, cycle, unused code
        send_word(CMD_QUERY, 8'd0, 8'd0);
        send_word(CMD_QUERY, 8'd255, 8'd255);
        send_word(CMD_QUERY, 8'd0, 8'd255);
        send_word(CMD_EDGE, 8'd0, 8'd255);
        send_word(CMD_EDGE, 8'd0, 8'd1);
        send_word(CMD_QUERY, 8'd255, 8'd1);
        send_word(CMD_EDGE, 8'd255, 8'd128);
        send_word(CMD_EDGE, 8'd1, 8'd127);
        send_word(CMD_QUERY, 8'd128, 8'd127);
        send_word(CMD_QUERY, 8'd128, 8'd255);
        send_word(CMD_QUERY, 8'd0, 8'd128);
        send_word(CMD_EDGE, 8'd1, 8'd128);
        send_word(CMD_QUERY, 8'd128, 8'd255);
        send_word(CMD_EDGE, 8'd7, 8'd7);
        send_word(CMD_QUERY, 8'd7, 8'd0);
        send_word(CMD_QUERY, 8'd0, 8'd7);
        send_word(CMD_EDGE, 8'd200, 8'd201);
        send_word(CMD_EDGE, 8'd201, 8'd200);
        send_word(CMD_QUERY, 8'd200, 8'd0);
        send_word(CMD_NONE, 8'hff, 8'hff);
        send_word(CMD_QUERY, 8'd127, 8'd128);
        send_word(CMD_CLEAR, 8'hff, 8'hff);
        send_word(CMD_QUERY, 8'd128, 8'd255);
        send_word(CMD_EDGE, 8'd255, 8'd0);
        send_word(CMD_QUERY, 8'd0, 8'd170);
        drain_answers();

        // random part: mostly well-formed trees, some noise, one full chain
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            if (!chain_done && words_sent - random_start > 500) begin
                chain_sequence();
                chain_done = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    7, 8: noise_words();
                    9: begin
                        drain_answers();
                        tree_sequence();
                    end
                    default: tree_sequence();
                endcase
            end
        end
        s_axis_tvalid <= 1'b0;

        // wait out every answer, then the longest walk the engine might still run
        @(posedge aclk);
        while (answers_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && answers_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lcapw_pkg.sv
rtl/core/lcapw_front.sv
rtl/core/lcapw_queue.sv
rtl/core/lcapw_back.sv
rtl/core/lowest_common_ancestor_parent_walk_unit.sv
tb/sv/lca_answer_checker.sv
tb/sv/lowest_common_ancestor_parent_walk_unit_tb.sv
